### src/twdbm_pkg.sv
package twdbm_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned CntWidth    = $clog2(BitsPerByte + 1);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_IDLE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_START = 3'd1,
    KIND_DATA  = 3'd2,
    KIND_STOP  = 3'd3,
    KIND_IDLE  = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    PH_FREE  = 5'b00001,
    PH_START = 5'b00010,
    PH_DATA  = 5'b00100,
    PH_STOP  = 5'b01000,
    PH_IDLE  = 5'b10000
  } phase_e;

endpackage

### src/two_wire_debug_byte_master.sv
// Master side of a two-wire debug link (clock line plus data line).
// Input channel (in_valid_i / in_ready_o) carries one request per accepted
// item: either a command (write byte, read byte, idle clocks) or a tick that
// clocks one period of the link. Commands are taken only while no earlier
// command is in progress; otherwise accepted_o comes back as 0.
// Output channel (out_valid_o / out_ready_i) returns exactly one result per
// request, describing the period clocked (start, data bit LSB first, stop or
// idle), the data line level and whether the master drives it, and for reads
// the assembled byte on the last data tick.
// The result is registered on acceptance and offered in the next cycle.
// Throughput: one request per cycle while results are taken, set by the single
// output register; all decoding lies between the input handshake and it.
// A stalled receiver holds the result in the output register; a new request
// is taken in the same cycle the held result is taken, so no bubble appears.
// Reset returns the link to free with the data line held high and clears
// the output valid.
module two_wire_debug_byte_master (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic       start_flag_i,
  input  logic       stop_flag_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] idle_count_i,
  input  logic       line_sample_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       accepted_o,
  output logic       clock_active_o,
  output logic [2:0] period_kind_o,
  output logic       line_level_o,
  output logic       line_driven_o,
  output logic       read_valid_o,
  output logic [7:0] read_byte_o,
  output logic       command_done_o
);
  import twdbm_pkg::*;

  phase_e              phase_q, phase_d;
  cmd_e                op_q, op_d;
  logic [CntWidth-1:0] bit_cnt_q, bit_cnt_d;
  logic [7:0]          shift_q, shift_d;
  logic [7:0]          left_q, left_d;
  logic                stop_lvl_q, stop_lvl_d;
  logic                held_q, held_d;

  logic       acc_d, clk_act_d, lvl_d, drv_d, rv_d, done_d;
  kind_e      kind_d;
  logic [7:0] rb_d;

  logic       out_valid_q;
  logic       acc_q, clk_act_q, lvl_q, drv_q, rv_q, done_q;
  logic [2:0] kind_q;
  logic [7:0] rb_q;

  logic take;
  cmd_e cmd;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(cmd_i);

  always_comb begin
    phase_d    = phase_q;
    op_d       = op_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    left_d     = left_q;
    stop_lvl_d = stop_lvl_q;
    held_d     = held_q;
    acc_d      = 1'b0;
    clk_act_d  = 1'b0;
    kind_d     = KIND_NONE;
    lvl_d      = held_q;
    drv_d      = 1'b1;
    rv_d       = 1'b0;
    rb_d       = 8'h00;
    done_d     = 1'b0;
    if (cmd != CMD_TICK) begin
      if (phase_q != PH_FREE) begin
        drv_d = !(phase_q == PH_DATA && op_q == CMD_READ);
        lvl_d = drv_d ? held_q : 1'b0;
      end else begin
        acc_d      = 1'b1;
        op_d       = cmd;
        bit_cnt_d  = '0;
        stop_lvl_d = stop_flag_i;
        if (cmd == CMD_IDLE) begin
          held_d = 1'b1;
          left_d = idle_count_i;
          if (idle_count_i == 8'h00) begin
            done_d = 1'b1;
          end else begin
            phase_d = PH_IDLE;
          end
        end else begin
          shift_d = (cmd == CMD_WRITE) ? data_byte_i : 8'h00;
          phase_d = start_flag_i ? PH_START : PH_DATA;
        end
        drv_d = !(phase_d == PH_DATA && cmd == CMD_READ);
        lvl_d = drv_d ? held_d : 1'b0;
      end
    end else begin
      unique case (phase_q)
        PH_START: begin
          held_d    = 1'b0;
          phase_d   = PH_DATA;
          clk_act_d = 1'b1;
          kind_d    = KIND_START;
          lvl_d     = 1'b0;
        end
        PH_DATA: begin
          clk_act_d = 1'b1;
          kind_d    = KIND_DATA;
          bit_cnt_d = bit_cnt_q + 1'b1;
          if (bit_cnt_d >= CntWidth'(BitsPerByte)) begin
            phase_d = PH_STOP;
          end
          if (op_q == CMD_READ) begin
            shift_d = {line_sample_i, shift_q[7:1]};
            drv_d   = 1'b0;
            rv_d    = (bit_cnt_d >= CntWidth'(BitsPerByte));
            rb_d    = rv_d ? shift_d : 8'h00;
          end else begin
            held_d  = shift_q[0];
            shift_d = {1'b0, shift_q[7:1]};
          end
          lvl_d = drv_d ? held_d : 1'b0;
        end
        PH_STOP: begin
          held_d    = stop_lvl_q;
          phase_d   = PH_FREE;
          clk_act_d = 1'b1;
          kind_d    = KIND_STOP;
          lvl_d     = stop_lvl_q;
          done_d    = 1'b1;
        end
        PH_IDLE: begin
          held_d    = 1'b1;
          left_d    = left_q - 8'h01;
          clk_act_d = 1'b1;
          kind_d    = KIND_IDLE;
          lvl_d     = 1'b1;
          if (left_d == 8'h00) begin
            phase_d = PH_FREE;
            done_d  = 1'b1;
          end
        end
        default: begin
          phase_d = PH_FREE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FREE;
      op_q        <= CMD_TICK;
      bit_cnt_q   <= '0;
      shift_q     <= 8'h00;
      left_q      <= 8'h00;
      stop_lvl_q  <= 1'b1;
      held_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q    <= phase_d;
        op_q       <= op_d;
        bit_cnt_q  <= bit_cnt_d;
        shift_q    <= shift_d;
        left_q     <= left_d;
        stop_lvl_q <= stop_lvl_d;
        held_q     <= held_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q     <= acc_d;
      clk_act_q <= clk_act_d;
      kind_q    <= kind_d;
      lvl_q     <= lvl_d;
      drv_q     <= drv_d;
      rv_q      <= rv_d;
      rb_q      <= rb_d;
      done_q    <= done_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = acc_q;
  assign clock_active_o = clk_act_q;
  assign period_kind_o  = kind_q;
  assign line_level_o   = lvl_q;
  assign line_driven_o  = drv_q;
  assign read_valid_o   = rv_q;
  assign read_byte_o    = rb_q;
  assign command_done_o = done_q;

endmodule

### src/twdbm_checker.sv
module twdbm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       accepted_o,
  input logic       clock_active_o,
  input logic [2:0] period_kind_o,
  input logic       line_driven_o,
  input logic       read_valid_o,
  input logic [7:0] read_byte_o
);
  import twdbm_pkg::*;

  // output register frees the input side whenever it is empty
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // no result appears without a request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !in_valid_i |=> !out_valid_o)
    else $error("result appeared without a request");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_byte_o)
      && $stable(period_kind_o))
    else $error("stalled result changed");

  // a taken command never clocks the link
  a_cmd_no_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> !clock_active_o && period_kind_o == KIND_NONE)
    else $error("accepted command produced a clock period");

  // a completed read is a released data period
  a_read_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> clock_active_o && !line_driven_o
      && period_kind_o == KIND_DATA)
    else $error("read byte outside a released data period");

endmodule

bind two_wire_debug_byte_master twdbm_checker u_twdbm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .accepted_o     (accepted_o),
  .clock_active_o (clock_active_o),
  .period_kind_o  (period_kind_o),
  .line_driven_o  (line_driven_o),
  .read_valid_o   (read_valid_o),
  .read_byte_o    (read_byte_o)
);

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import twdbm_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldOff    = 60;

  typedef struct packed {
    cmd_e       cmd;
    logic       start;
    logic       stop;
    logic [7:0] data;
    logic [7:0] count;
    logic       sample;
  } link_item_t;

  typedef struct packed {
    logic       accepted;
    logic       clock_active;
    kind_e      kind;
    logic       level;
    logic       driven;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       done;
  } link_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] cmd_i;
  logic       start_flag_i;
  logic       stop_flag_i;
  logic [7:0] data_byte_i;
  logic [7:0] idle_count_i;
  logic       line_sample_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       accepted_o;
  logic       clock_active_o;
  logic [2:0] period_kind_o;
  logic       line_level_o;
  logic       line_driven_o;
  logic       read_valid_o;
  logic [7:0] read_byte_o;
  logic       command_done_o;

  // link state as predicted
  phase_e                link_phase;
  cmd_e                  link_op;
  logic [CntWidth-1:0]   bits_done;
  logic [7:0]            shift_reg;
  logic [7:0]            idle_left;
  logic                  stop_level_q;
  logic                  held_level;

  link_result_t pending_results[$];
  int unsigned  mismatches;
  int unsigned  rx_hold_cycles;
  bit           tx_gaps_on;
  bit           rx_gaps_on;

  two_wire_debug_byte_master dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .start_flag_i   (start_flag_i),
    .stop_flag_i    (stop_flag_i),
    .data_byte_i    (data_byte_i),
    .idle_count_i   (idle_count_i),
    .line_sample_i  (line_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .clock_active_o (clock_active_o),
    .period_kind_o  (period_kind_o),
    .line_level_o   (line_level_o),
    .line_driven_o  (line_driven_o),
    .read_valid_o   (read_valid_o),
    .read_byte_o    (read_byte_o),
    .command_done_o (command_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void reset_link();
    link_phase   = PH_FREE;
    link_op      = CMD_TICK;
    bits_done    = '0;
    shift_reg    = 8'h00;
    idle_left    = 8'h00;
    stop_level_q = 1'b1;
    held_level   = 1'b1;
  endfunction

  function automatic link_result_t clock_link(input link_item_t it);
    link_result_t r;
    r = '0;
    if (it.cmd != CMD_TICK) begin
      if (link_phase != PH_FREE) begin
        // busy, command dropped
        r.driven = !(link_phase == PH_DATA && link_op == CMD_READ);
        r.level  = r.driven & held_level;
        return r;
      end
      link_op      = it.cmd;
      bits_done    = '0;
      stop_level_q = it.stop;
      if (it.cmd == CMD_IDLE) begin
        held_level = 1'b1;
        idle_left  = it.count;
        if (it.count == 8'h00) begin
          link_phase = PH_FREE;
          r.done     = 1'b1;
        end else begin
          link_phase = PH_IDLE;
        end
      end else begin
        shift_reg  = (it.cmd == CMD_WRITE) ? it.data : 8'h00;
        link_phase = it.start ? PH_START : PH_DATA;
      end
      r.accepted = 1'b1;
      r.driven   = !(link_phase == PH_DATA && link_op == CMD_READ);
      r.level    = r.driven & held_level;
      return r;
    end
    case (link_phase)
      PH_START: begin
        held_level     = 1'b0;
        link_phase     = PH_DATA;
        r.clock_active = 1'b1;
        r.kind         = KIND_START;
        r.driven       = 1'b1;
      end
      PH_DATA: begin
        r.clock_active = 1'b1;
        r.kind         = KIND_DATA;
        bits_done      = bits_done + 1'b1;
        if (link_op == CMD_READ) begin
          shift_reg = {it.sample, shift_reg[7:1]};
          if (bits_done >= BitsPerByte) begin
            link_phase = PH_STOP;
            r.rd_valid = 1'b1;
            r.rd_byte  = shift_reg;
          end
        end else begin
          r.level    = shift_reg[0];
          r.driven   = 1'b1;
          held_level = shift_reg[0];
          shift_reg  = shift_reg >> 1;
          if (bits_done >= BitsPerByte) link_phase = PH_STOP;
        end
      end
      PH_STOP: begin
        held_level     = stop_level_q;
        link_phase     = PH_FREE;
        r.clock_active = 1'b1;
        r.kind         = KIND_STOP;
        r.level        = stop_level_q;
        r.driven       = 1'b1;
        r.done         = 1'b1;
      end
      PH_IDLE: begin
        held_level     = 1'b1;
        idle_left      = idle_left - 8'd1;
        if (idle_left == 8'h00) link_phase = PH_FREE;
        r.clock_active = 1'b1;
        r.kind         = KIND_IDLE;
        r.level        = 1'b1;
        r.driven       = 1'b1;
        r.done         = (idle_left == 8'h00);
      end
      default: begin
        link_phase = PH_FREE;
        r.level    = held_level;
        r.driven   = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [7:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return 8'($urandom_range(0, 6));
    if (roll < 19) return 8'($urandom_range(7, 40));
    return 8'($urandom_range(41, 255));
  endfunction

  function automatic link_item_t random_item();
    link_item_t it;
    it.cmd    = cmd_e'($urandom_range(0, 3));
    it.start  = 1'($urandom_range(0, 1));
    it.stop   = 1'($urandom_range(0, 1));
    it.data   = 8'($urandom_range(0, 255));
    it.count  = 8'($urandom_range(0, 255));
    it.sample = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic link_item_t make_item(input cmd_e cmd, input logic start,
                                           input logic stop, input logic [7:0] data,
                                           input logic [7:0] count, input logic sample);
    link_item_t it;
    it.cmd    = cmd;
    it.start  = start;
    it.stop   = stop;
    it.data   = data;
    it.count  = count;
    it.sample = sample;
    return it;
  endfunction

  // called at a rising edge, returns at the edge that takes the request or after a random idle gap behind it
  task automatic send_item(input link_item_t it);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    cmd_i         <= it.cmd;
    start_flag_i  <= it.start;
    stop_flag_i   <= it.stop;
    data_byte_i   <= it.data;
    idle_count_i  <= it.count;
    line_sample_i <= it.sample;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pending_results.push_back(clock_link(it));
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_ticks(input int unsigned n, input logic [7:0] samples);
    for (int unsigned i = 0; i < n; i++) begin
      send_item(make_item(CMD_TICK, 1'b0, 1'b0, 8'h00, 8'h00, samples[i[2:0]]));
    end
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %0h, got %0h", field, want, got);
      end
    end
  endtask

  task automatic test_directed();
    send_item(make_item(CMD_TICK, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b1));
    send_item(make_item(CMD_WRITE, 1'b1, 1'b0, 8'hA5, 8'h00, 1'b0));
    send_ticks(1, 8'h00);
    // command while busy is dropped
    send_item(make_item(CMD_READ, 1'b0, 1'b1, 8'h00, 8'h00, 1'b0));
    send_ticks(9, 8'h00);
    send_item(make_item(CMD_READ, 1'b0, 1'b1, 8'hFF, 8'hFF, 1'b1));
    send_ticks(9, 8'b1100_1010);
    send_item(make_item(CMD_IDLE, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
    send_item(make_item(CMD_IDLE, 1'b1, 1'b1, 8'hFF, 8'h01, 1'b1));
    send_ticks(1, 8'hFF);
  endtask

  // well-formed commands with random content, plus stray ticks and busy commands
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    link_item_t  it;
    sent = 0;
    while (sent < n_items) begin
      it = random_item();
      if (link_phase == PH_FREE) begin
        if ($urandom_range(0, 9) == 0) begin
          it.cmd = CMD_TICK;
        end else begin
          it.cmd   = cmd_e'($urandom_range(1, 3));
          it.count = pick_count();
          sent++;
        end
      end else if ($urandom_range(0, 7) != 0) begin
        it.cmd = CMD_TICK;
        sent++;
      end else if (it.cmd == CMD_TICK) begin
        it.cmd = CMD_WRITE;
      end
      send_item(it);
    end
  endtask

  task automatic test_back_to_back();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    test_random_traffic(150);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_input_stall();
    tx_gaps_on     = 1'b0;
    rx_hold_cycles = HoldOff;
    test_random_traffic(60);
    tx_gaps_on     = 1'b1;
  endtask

  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall == 0 && rx_gaps_on) stall = pick_gap();
      if (rx_hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        rx_hold_cycles--;
      end else if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : result_check
    link_result_t want;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result arrived with none outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("accepted", 8'(want.accepted), 8'(accepted_o));
          check_field("clock_active", 8'(want.clock_active), 8'(clock_active_o));
          check_field("period_kind", 8'(want.kind), 8'(period_kind_o));
          check_field("line_level", 8'(want.level), 8'(line_level_o));
          check_field("line_driven", 8'(want.driven), 8'(line_driven_o));
          check_field("read_valid", 8'(want.rd_valid), 8'(read_valid_o));
          check_field("read_byte", want.rd_byte, read_byte_o);
          check_field("command_done", 8'(want.done), 8'(command_done_o));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_ready_o === 1'b1) ||
          (out_valid_o === 1'b1 && out_ready_i === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[two_wire_debug_byte_master] ERROR");
    $finish;
  end

  initial begin : stimulus
    mismatches     = 0;
    rx_hold_cycles = 0;
    tx_gaps_on     = 1'b1;
    rx_gaps_on     = 1'b1;
    reset_link();
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    cmd_i         <= CMD_TICK;
    start_flag_i  <= 1'b0;
    stop_flag_i   <= 1'b0;
    data_byte_i   <= 8'h00;
    idle_count_i  <= 8'h00;
    line_sample_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_back_to_back();
    test_input_stall();
    test_random_traffic(1450);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[two_wire_debug_byte_master] OK");
    end else begin
      $display("[two_wire_debug_byte_master] ERROR");
    end
    $finish;
  end

endmodule

### files.f
src/twdbm_pkg.sv
src/two_wire_debug_byte_master.sv
src/twdbm_checker.sv
dv/testbench.sv
